@@ rtl/bpda_pkg.sv @@
// Shared types and constants for the button press duration adjuster.
// Used by the configuration register file and the top level; no dependencies.
package bpda_pkg;

    // Width of each button's tick counter.
    localparam int CountWidth = 16;
    // Width used when a counter is compared against a 16-bit threshold.
    localparam int CmpWidth = (CountWidth > 16) ? CountWidth : 16;

    localparam int CfgIndexWidth = 3;
    localparam int CfgDataWidth  = 16;

    // Configuration register indexes.
    localparam logic [CfgIndexWidth-1:0] REG_SHORT_LOW    = 3'd0;
    localparam logic [CfgIndexWidth-1:0] REG_SHORT_HIGH   = 3'd1;
    localparam logic [CfgIndexWidth-1:0] REG_LONG_THRESH  = 3'd2;
    localparam logic [CfgIndexWidth-1:0] REG_VOLUME_LIMIT = 3'd3;
    localparam logic [CfgIndexWidth-1:0] REG_CHAN_LIMIT   = 3'd4;
    localparam logic [CfgIndexWidth-1:0] REG_RELEASED_LVL = 3'd5;

    // Event codes reported with each result item.
    typedef enum logic [2:0] {
        EV_NONE      = 3'd0,
        EV_VOL_UP    = 3'd1,
        EV_VOL_DOWN  = 3'd2,
        EV_CHAN_UP   = 3'd3,
        EV_CHAN_DOWN = 3'd4
    } t_event;

    // Current configuration as seen by the datapath.
    typedef struct packed {
        logic [15:0] short_low;
        logic [15:0] short_high;
        logic [15:0] long_thresh;
        logic [3:0]  volume_limit;
        logic [7:0]  chan_limit;
        logic        released_level;
    } t_cfg;

endpackage

@@ rtl/bpda_cfg_regs.sv @@
// Configuration register file for the button press duration adjuster.
// Depends on bpda_pkg for register indexes and the t_cfg struct.
module bpda_cfg_regs
    import bpda_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_valid,
    input  logic [CfgIndexWidth-1:0] i_cfg_index,
    input  logic [CfgDataWidth-1:0]  i_cfg_data,
    output t_cfg                     o_cfg
);

    t_cfg r_cfg;

    // Writes land one register per item; unknown indexes are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.short_low      <= 16'd1200;
            r_cfg.short_high     <= 16'd1500;
            r_cfg.long_thresh    <= 16'd2000;
            r_cfg.volume_limit   <= 4'd8;
            r_cfg.chan_limit     <= 8'd15;
            r_cfg.released_level <= 1'b1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_SHORT_LOW:    r_cfg.short_low      <= i_cfg_data;
                REG_SHORT_HIGH:   r_cfg.short_high     <= i_cfg_data;
                REG_LONG_THRESH:  r_cfg.long_thresh    <= i_cfg_data;
                REG_VOLUME_LIMIT: r_cfg.volume_limit   <= i_cfg_data[3:0];
                REG_CHAN_LIMIT:   r_cfg.chan_limit     <= i_cfg_data[7:0];
                REG_RELEASED_LVL: r_cfg.released_level <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ rtl/button_press_duration_adjuster.sv @@
// Top level of the button press duration adjuster: input register, press
// classification and volume/channel update, result register.
// Depends on bpda_pkg and bpda_cfg_regs.
// Input acceptance to result valid passes the input register, then the result register.
// Throughput: one item per cycle while i_out_stall is low; the state update and result
// register sit behind a single input register stage with no feedback bubble.
// Reset: synchronous, active low; counters stopped and cleared, volume and
// channel zero, configuration registers at their default values.
module button_press_duration_adjuster
    import bpda_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // Input items
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic                     i_func,
    input  logic                     i_which_button,
    input  logic                     i_pin_level,
    // Result items
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [2:0]               o_event_code,
    output logic [3:0]               o_volume_now,
    output logic [7:0]               o_channel_now,
    // Configuration writes
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CfgIndexWidth-1:0] i_cfg_index,
    input  logic [CfgDataWidth-1:0]  i_cfg_data
);

    localparam logic [CountWidth-1:0] CountMax = {CountWidth{1'b1}};

    t_cfg w_cfg;

    logic r_s1_valid;
    logic r_s1_func;
    logic r_s1_button;
    logic r_s1_level;

    logic [CountWidth-1:0] r_count [2];
    logic [1:0]            r_counting;
    logic [3:0]            r_volume;
    logic [7:0]            r_channel;

    logic       r_out_valid;
    t_event     r_out_event;

    logic                  w_advance;
    logic                  w_fire;
    logic                  w_released;
    logic [CountWidth-1:0] w_cur;
    logic [CountWidth-1:0] w_inc;
    logic [CmpWidth-1:0]   w_cmp;
    logic                  w_short;
    logic                  w_long;
    logic [4:0]            w_vol_up;
    logic [3:0]            w_vol_dn;
    logic [8:0]            w_chan_up;

    logic [CountWidth-1:0] n_count;
    logic                  n_counting;
    logic [3:0]            n_volume;
    logic [7:0]            n_channel;
    t_event                n_event;

    bpda_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    assign o_cfg_ready = 1'b1;

    // Handshake: the result register frees when empty or taken downstream.
    assign w_advance  = !r_out_valid || !i_out_stall;
    assign w_fire     = r_s1_valid && w_advance;
    assign o_in_stall = r_s1_valid && !w_advance;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_s1_valid <= i_in_valid;
        end
        if (!o_in_stall && i_in_valid) begin
            r_s1_func   <= i_func;
            r_s1_button <= i_which_button;
            r_s1_level  <= i_pin_level;
        end
    end

    // Counter advance and window tests for the addressed button.
    assign w_released = (r_s1_level == w_cfg.released_level);
    assign w_cur      = r_count[r_s1_button];
    assign w_inc      = (w_cur == CountMax) ? w_cur : w_cur + 1'b1;
    assign w_cmp      = CmpWidth'(w_inc);
    assign w_short    = (w_cmp > CmpWidth'(w_cfg.short_low)) &&
                        (w_cmp < CmpWidth'(w_cfg.short_high));
    assign w_long     = (w_cmp > CmpWidth'(w_cfg.long_thresh));

    // Saturating volume and channel steps.
    assign w_vol_up  = {1'b0, r_volume} + 5'd1;
    assign w_vol_dn  = (r_volume == 4'd0) ? 4'd0 : r_volume - 4'd1;
    assign w_chan_up = {1'b0, r_channel} + 9'd1;

    // Next state of the addressed counter, volume, channel and the event.
    always_comb begin
        n_count    = w_cur;
        n_counting = r_counting[r_s1_button];
        n_volume   = r_volume;
        n_channel  = r_channel;
        n_event    = EV_NONE;
        if (!r_s1_func) begin
            if (!w_released) begin
                n_counting = 1'b1;
            end
        end else if (r_counting[r_s1_button]) begin
            n_count = w_inc;
            if (w_short) begin
                if (w_released) begin
                    n_count    = '0;
                    n_counting = 1'b0;
                    if (!r_s1_button) begin
                        n_volume = (w_vol_up > {1'b0, w_cfg.volume_limit}) ?
                                   w_cfg.volume_limit : w_vol_up[3:0];
                        n_event  = EV_VOL_UP;
                    end else begin
                        n_volume = (w_vol_dn > w_cfg.volume_limit) ?
                                   w_cfg.volume_limit : w_vol_dn;
                        n_event  = EV_VOL_DOWN;
                    end
                end
            end else if (w_long) begin
                if (w_released) begin
                    n_count    = '0;
                    n_counting = 1'b0;
                    if (!r_s1_button) begin
                        n_channel = (w_chan_up > {1'b0, w_cfg.chan_limit}) ?
                                    w_cfg.chan_limit : w_chan_up[7:0];
                        n_event   = EV_CHAN_UP;
                    end else if (r_channel != 8'd0) begin
                        n_channel = r_channel - 8'd1;
                        n_event   = EV_CHAN_DOWN;
                    end
                end
            end
        end
    end

    // Button state, shared volume/channel and the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count[0]  <= '0;
            r_count[1]  <= '0;
            r_counting  <= 2'b00;
            r_volume    <= 4'd0;
            r_channel   <= 8'd0;
            r_out_valid <= 1'b0;
            r_out_event <= EV_NONE;
        end else begin
            if (w_advance) begin
                r_out_valid <= r_s1_valid;
            end
            if (w_fire) begin
                r_count[r_s1_button]    <= n_count;
                r_counting[r_s1_button] <= n_counting;
                r_volume                <= n_volume;
                r_channel               <= n_channel;
                r_out_event             <= n_event;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_event_code  = r_out_event;
    assign o_volume_now  = r_volume;
    assign o_channel_now = r_channel;

endmodule
